[hdl/cfh_pkg.sv]
package cfh_pkg;

   localparam int unsigned HASH_W = 32;
   localparam int unsigned CHAR_W = 16;

   localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
   localparam int unsigned PARITY_BIT_POS = 7;

   typedef enum logic [1:0] {
      CSR_START_VALUE  = 2'd0,
      CSR_START_PARITY = 2'd1,
      CSR_FOLD_MODE    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      FOLD_FULL = 2'd0,
      FOLD_16   = 2'd1,
      FOLD_20   = 2'd2
   } fold_mode_type;

   // ascii a-z to upper case, everything else untouched
   function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 16'h0061 && c <= 16'h007A) begin
         r = c - 16'h0020;
      end
      return r;
   endfunction

   // h * 0x01000193 mod 2^32 as shift-add
   function automatic logic [HASH_W-1:0] mul_prime(input logic [HASH_W-1:0] h);
      return (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
   endfunction

   function automatic logic [HASH_W-1:0] make_digest(input logic [HASH_W-1:0] h,
                                                     input logic [1:0] mode);
      logic [HASH_W-1:0] d;
      unique case (mode)
         FOLD_16: d = {16'b0, h[31:16] ^ h[15:0]};
         FOLD_20: d = {12'b0, {8'b0, h[31:20]} ^ h[19:0]};
         default: d = h;
      endcase
      return d;
   endfunction

endpackage

[hdl/case_folded_fnv1a32_hasher.sv]
// an accepted item enters the input register; a last item then loads the result register
// behind rsp_tdata. throughput: one item per cycle, set by the combinational hash update
// from the input register to the running hash register, unless an untaken result stalls a last item
// reset (synchronous, active high): start_value 0x811c9dc5, start_parity 0,
// fold_mode 0, no message open, both item registers empty
module case_folded_fnv1a32_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // char_code[15:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // raw_hash[31:0], digest[63:32]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] start_value_ff,  start_value_in;
   logic        start_parity_ff, start_parity_in;
   logic [1:0]  fold_mode_ff,    fold_mode_in;

   logic        in_valid_ff, in_valid_in;
   logic [15:0] in_char_ff,  in_char_in;
   logic        in_last_ff,  in_last_in;

   logic [31:0] hash_ff,   hash_in;
   logic        parity_ff, parity_in;
   logic        open_ff,   open_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_data_ff,  rsp_data_in;

   logic        adv;
   logic [31:0] base_hash;
   logic        base_parity;
   logic [31:0] mixed;
   logic [31:0] next_hash;

   // csr writes
   always_comb begin
      start_value_in  = start_value_ff;
      start_parity_in = start_parity_ff;
      fold_mode_in    = fold_mode_ff;
      if (csr_we) begin
         case (csr_index)
            cfh_pkg::CSR_START_VALUE:  start_value_in  = csr_wdata;
            cfh_pkg::CSR_START_PARITY: start_parity_in = csr_wdata[0];
            cfh_pkg::CSR_FOLD_MODE:    fold_mode_in    = csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // stage advance: a last item needs room in the result register
   assign adv        = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_char_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   assign base_hash   = open_ff ? hash_ff : start_value_ff;
   assign base_parity = open_ff ? parity_ff : start_parity_ff;
   assign mixed       = base_hash
                        ^ {16'b0, cfh_pkg::fold_upper(in_char_ff)}
                        ^ ({31'b0, base_parity} << cfh_pkg::PARITY_BIT_POS);
   assign next_hash   = cfh_pkg::mul_prime(mixed);

   always_comb begin
      hash_in      = hash_ff;
      parity_in    = parity_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (adv) begin
         hash_in   = next_hash;
         parity_in = !base_parity;
         open_in   = !in_last_ff;
         if (in_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {cfh_pkg::make_digest(next_hash, fold_mode_ff), next_hash};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff  <= cfh_pkg::FNV_BASIS;
         start_parity_ff <= 1'b0;
         fold_mode_ff    <= cfh_pkg::FOLD_FULL;
         in_valid_ff     <= 1'b0;
         open_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         start_value_ff  <= start_value_in;
         start_parity_ff <= start_parity_in;
         fold_mode_ff    <= fold_mode_in;
         in_valid_ff     <= in_valid_in;
         open_ff         <= open_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff  <= in_char_in;
      in_last_ff  <= in_last_in;
      hash_ff     <= hash_in;
      parity_ff   <= parity_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (adv && in_last_ff) |=> rsp_tvalid)
      else $error("last item did not load a result");

   a_mid_keeps_open: assert property (@(posedge clock) disable iff (reset)
      (adv && !in_last_ff) |=> open_ff)
      else $error("message closed on a non-last item");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (adv && in_last_ff) |=> !open_ff)
      else $error("message still open after last item");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked result");

endmodule
